@@ rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: opcodes, error codes and widths.
package rau_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_MUL    = 3'd1,
        OP_DIV    = 3'd2,
        OP_LESS   = 3'd3,
        OP_GREAT  = 3'd4,
        OP_REDUCE = 3'd5,
        OP_SCALE  = 3'd6,
        OP_NONE   = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_SCALE = 2'd2,
        ERR_RSVD  = 2'd3
    } err_t;

    // Request and reply between the sequencer and the shared divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer around a shared divider.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, opcode, a_num..scale_factor  | receive
//   out     | out_valid, out_stall, res_num, res_den,          | send
//           | compare_true, error_code                         |
//
// One item is worked on at a time, and in_stall is high whenever the sequencer is not idle.
// Each division is issued, then the divider is started, then it works out the quotient
// bits, and then the result is collected. A GCD needs one division per Euclid step.
// Scale and the unused opcode use no division.
// Reset clears the sequencer and out_valid. A result that waits in the output register
// holds the sequencer at its final step until the result item is taken.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
    input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
    input  logic signed [rau_pkg::FIELD_W-1:0] scale_factor,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [rau_pkg::FIELD_W-1:0] res_num,
    output logic signed [rau_pkg::FIELD_W-1:0] res_den,
    output logic                          compare_true,
    output logic [1:0]                    error_code
);

    localparam int FW = rau_pkg::FIELD_W;

    // Sequencer states, one-hot. Every multiply goes through the single multiplier
    // and every divide and Euclid step through the shared divider.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,  // first product, pick the path
        S_MUL   = 7'b0000100,  // denominator product
        S_STEP  = 7'b0001000,  // advance the micro-program
        S_GCD   = 7'b0010000,  // one Euclid step is running
        S_GDIV  = 7'b0100000,  // a plain division is running
        S_OUT   = 7'b1000000   // load the output register
    } state_t;

    // Micro-program positions for the multi-step opcodes, one-hot.
    typedef enum logic [9:0] {
        P_LCM_G = 10'b0000000001,  // gcd(ad, bd)
        P_LCM_D = 10'b0000000010,  // l = (ad*bd) / g
        P_KA    = 10'b0000000100,  // l / ad (add) or fn*l / fd (compare)
        P_KB    = 10'b0000001000,  // l / bd (add) or dn*l / dd (compare)
        P_SUM   = 10'b0000010000,  // an*ka + bn*kb, or the compare itself
        P_RED_Z = 10'b0000100000,  // check the denominator, load the Euclid pair
        P_RED_G = 10'b0001000000,  // gcd(n, d)
        P_RED_N = 10'b0010000000,  // n / g
        P_RED_D = 10'b0100000000,  // d / g and sign fix
        P_FIN   = 10'b1000000000
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            ph_reg, ph_next;
    rau_pkg::opcode_t  op_reg, op_next;
    logic [WIDTH-1:0]  an_reg, an_next, ad_reg, ad_next;
    logic [WIDTH-1:0]  bn_reg, bn_next, bd_reg, bd_next;
    logic [WIDTH-1:0]  k_reg, k_next;
    logic [WIDTH-1:0]  ga_reg, ga_next, gb_reg, gb_next;   // Euclid pair
    logic [WIDTH-1:0]  n_reg, n_next, d_reg, d_next;       // value being reduced
    logic [WIDTH-1:0]  l_reg, l_next, g_reg, g_next;
    logic [WIDTH-1:0]  x_reg, x_next, y_reg, y_next;
    logic              err_reg, err_next;
    logic              half_reg, half_next;                // second product of the sum
    logic              cmpw_reg, cmpw_next;
    logic              out_v_reg, out_v_next;
    logic [FW-1:0]     rn_reg, rn_next, rd_reg, rd_next;
    logic              cmp_reg, cmp_next;
    logic [1:0]        ec_reg, ec_next;
    rau_pkg::err_t     ec_sel;
    logic              load_out;

    // Shared multiplier: one WIDTH x WIDTH product, wrapped.
    logic [WIDTH-1:0]  mul_a, mul_b, mul_p;

    rau_pkg::div_ctl_t div_ctl;
    rau_pkg::div_sts_t div_sts;
    logic [WIDTH-1:0]  div_q, div_r;
    logic [WIDTH-1:0]  div_a_reg, div_a_next, div_b_reg, div_b_next;
    logic              div_go;
    logic              div_start_reg;

    logic is_add, is_cmp;

    assign mul_p = mul_a * mul_b;

    // The operands are registered together with the go request, so the divider
    // is started in the cycle after the request, when its operand registers already hold them.
    assign div_ctl.start = div_start_reg;

    rau_divider #(.WIDTH(WIDTH)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .sts       (div_sts),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Inputs are sign extended and then wrapped to WIDTH bits.
    function automatic logic [WIDTH-1:0] sext(input logic [FW-1:0] v);
        return WIDTH'($signed(v));
    endfunction

    // Results are WIDTH-bit patterns; only their low bits reach the ports.
    function automatic logic [FW-1:0] trunc(input logic [WIDTH-1:0] v);
        return FW'(v);
    endfunction

    assign is_add = (op_reg == rau_pkg::OP_ADD);
    assign is_cmp = (op_reg == rau_pkg::OP_LESS) || (op_reg == rau_pkg::OP_GREAT);

    assign load_out = (state_reg == S_OUT) && (!out_v_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        op_next    = op_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        k_next  = k_reg;
        ga_next = ga_reg; gb_next = gb_reg;
        n_next  = n_reg;  d_next  = d_reg;
        l_next  = l_reg;  g_next  = g_reg;
        x_next  = x_reg;  y_next  = y_reg;
        err_next  = err_reg;
        half_next = half_reg;
        cmpw_next = cmpw_reg;
        div_a_next = div_a_reg;
        div_b_next = div_b_reg;
        div_go = 1'b0;
        mul_a  = an_reg;
        mul_b  = bn_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = rau_pkg::opcode_t'(opcode);
                    // The greater test is the less test with the fractions swapped.
                    if (opcode == rau_pkg::OP_GREAT)
                    begin
                        an_next = sext(b_num); ad_next = sext(b_den);
                        bn_next = sext(a_num); bd_next = sext(a_den);
                    end
                    else
                    begin
                        an_next = sext(a_num); ad_next = sext(a_den);
                        bn_next = sext(b_num); bd_next = sext(b_den);
                    end
                    k_next    = sext(scale_factor);
                    err_next  = 1'b0;
                    half_next = 1'b0;
                    cmpw_next = 1'b0;
                    state_next = S_SETUP;
                end
            end

            S_SETUP:
            begin
                unique case (op_reg)
                    rau_pkg::OP_MUL:
                    begin
                        mul_a = an_reg; mul_b = bn_reg;
                        n_next = mul_p;
                        state_next = S_MUL;
                    end
                    rau_pkg::OP_DIV:
                    begin
                        mul_a = an_reg; mul_b = bd_reg;
                        n_next = mul_p;
                        state_next = S_MUL;
                    end
                    rau_pkg::OP_REDUCE:
                    begin
                        n_next = an_reg;
                        d_next = ad_reg;
                        ph_next = P_RED_Z;
                        state_next = S_STEP;
                    end
                    rau_pkg::OP_SCALE:
                    begin
                        if (k_reg == '0)
                        begin
                            // A zero scale factor only sets the error code.
                            ph_next = P_FIN;
                            state_next = S_STEP;
                        end
                        else
                        begin
                            mul_a = an_reg; mul_b = k_reg;
                            n_next = mul_p;
                            state_next = S_MUL;
                        end
                    end
                    rau_pkg::OP_ADD, rau_pkg::OP_LESS, rau_pkg::OP_GREAT:
                    begin
                        ga_next = ad_reg;
                        gb_next = bd_reg;
                        ph_next = P_LCM_G;
                        state_next = S_STEP;
                    end
                    default:
                    begin
                        ph_next = P_FIN;
                        state_next = S_STEP;
                    end
                endcase
            end

            S_MUL:
            begin
                // Second product of a pair: the denominator.
                unique case (op_reg)
                    rau_pkg::OP_DIV:   begin mul_a = ad_reg; mul_b = bn_reg; end
                    rau_pkg::OP_SCALE: begin mul_a = ad_reg; mul_b = k_reg;  end
                    default:           begin mul_a = ad_reg; mul_b = bd_reg; end
                endcase
                d_next = mul_p;
                // Scaling is not reduced to lowest terms.
                ph_next = (op_reg == rau_pkg::OP_SCALE) ? P_FIN : P_RED_Z;
                state_next = S_STEP;
            end

            S_STEP:
            begin
                unique case (ph_reg)
                    P_LCM_G:
                    begin
                        // Euclid on (ga, gb); finish when either side is zero.
                        priority if (gb_reg == '0)
                        begin
                            g_next = ga_reg;
                            ph_next = P_LCM_D;
                        end
                        else if (ga_reg == '0)
                        begin
                            g_next = gb_reg;
                            ph_next = P_LCM_D;
                        end
                        else
                        begin
                            div_a_next = ga_reg;
                            div_b_next = gb_reg;
                            div_go = 1'b1;
                            state_next = S_GCD;
                        end
                    end
                    P_LCM_D:
                    begin
                        mul_a = ad_reg; mul_b = bd_reg;
                        if (g_reg == '0)
                        begin
                            // Any error zeroes every output, so stop right here.
                            err_next = 1'b1;
                            ph_next = P_FIN;
                        end
                        else
                        begin
                            div_a_next = mul_p;
                            div_b_next = g_reg;
                            div_go = 1'b1;
                            state_next = S_GDIV;
                        end
                    end
                    P_KA:
                    begin
                        mul_a = an_reg; mul_b = l_reg;
                        if (ad_reg == '0)
                        begin
                            err_next = 1'b1;
                            ph_next = P_FIN;
                        end
                        else
                        begin
                            div_a_next = is_add ? l_reg : mul_p;
                            div_b_next = ad_reg;
                            div_go = 1'b1;
                            state_next = S_GDIV;
                        end
                    end
                    P_KB:
                    begin
                        mul_a = bn_reg; mul_b = l_reg;
                        if (bd_reg == '0)
                        begin
                            err_next = 1'b1;
                            ph_next = P_FIN;
                        end
                        else
                        begin
                            div_a_next = is_add ? l_reg : mul_p;
                            div_b_next = bd_reg;
                            div_go = 1'b1;
                            state_next = S_GDIV;
                        end
                    end
                    P_SUM:
                    begin
                        if (is_cmp)
                        begin
                            cmpw_next = ($signed(x_reg) < $signed(y_reg));
                            ph_next   = P_FIN;
                        end
                        else if (!half_reg)
                        begin
                            // Two products in turn: an*ka first, then bn*kb.
                            mul_a = an_reg; mul_b = x_reg;
                            n_next = mul_p;
                            half_next = 1'b1;
                        end
                        else
                        begin
                            mul_a = bn_reg; mul_b = y_reg;
                            n_next = n_reg + mul_p;
                            d_next = l_reg;
                            half_next = 1'b0;
                            ph_next = P_RED_Z;
                        end
                    end
                    P_RED_Z:
                    begin
                        if (d_reg == '0)
                        begin
                            err_next = 1'b1;
                            ph_next = P_FIN;
                        end
                        else
                        begin
                            ga_next = n_reg;
                            gb_next = d_reg;
                            ph_next = P_RED_G;
                        end
                    end
                    P_RED_G:
                    begin
                        priority if (gb_reg == '0)
                        begin
                            g_next = ga_reg;
                            ph_next = P_RED_N;
                        end
                        else if (ga_reg == '0)
                        begin
                            g_next = gb_reg;
                            ph_next = P_RED_N;
                        end
                        else
                        begin
                            div_a_next = ga_reg;
                            div_b_next = gb_reg;
                            div_go = 1'b1;
                            state_next = S_GCD;
                        end
                    end
                    P_RED_N:
                    begin
                        // The denominator is nonzero here, so the GCD is too.
                        div_a_next = n_reg;
                        div_b_next = g_reg;
                        div_go = 1'b1;
                        state_next = S_GDIV;
                    end
                    P_RED_D:
                    begin
                        div_a_next = d_reg;
                        div_b_next = g_reg;
                        div_go = 1'b1;
                        state_next = S_GDIV;
                    end
                    P_FIN:
                    begin
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_GCD:
            begin
                if (div_sts.done)
                begin
                    ga_next = gb_reg;
                    gb_next = div_r;
                    state_next = S_STEP;
                end
            end

            S_GDIV:
            begin
                if (div_sts.done)
                begin
                    state_next = S_STEP;
                    unique case (ph_reg)
                        P_LCM_D: begin l_next = div_q; ph_next = P_KA;    end
                        P_KA:    begin x_next = div_q; ph_next = P_KB;    end
                        P_KB:    begin y_next = div_q; ph_next = P_SUM;   end
                        P_RED_N: begin n_next = div_q; ph_next = P_RED_D; end
                        P_RED_D:
                        begin
                            // Make the denominator positive.
                            if (div_q[WIDTH-1])
                            begin
                                n_next = ~n_reg + 1'b1;
                                d_next = ~div_q + 1'b1;
                            end
                            else
                            begin
                                d_next = div_q;
                            end
                            ph_next = P_FIN;
                        end
                        default: ph_next = P_FIN;
                    endcase
                end
            end

            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result item: the error code decides whether any value goes out.
    always_comb
    begin
        if (err_reg)
        begin
            ec_sel = rau_pkg::ERR_DIV0;
        end
        else if (op_reg == rau_pkg::OP_SCALE && k_reg == '0)
        begin
            ec_sel = rau_pkg::ERR_SCALE;
        end
        else
        begin
            ec_sel = rau_pkg::ERR_OK;
        end

        rn_next  = rn_reg;
        rd_next  = rd_reg;
        cmp_next = cmp_reg;
        ec_next  = ec_reg;
        out_v_next = out_v_reg;
        if (out_v_reg && !out_stall)
        begin
            out_v_next = 1'b0;
        end
        if (load_out)
        begin
            out_v_next = 1'b1;
            ec_next    = ec_sel;
            if (ec_sel != rau_pkg::ERR_OK || is_cmp || op_reg == rau_pkg::OP_NONE)
            begin
                rn_next = '0;
                rd_next = '0;
            end
            else
            begin
                rn_next = trunc(n_reg);
                rd_next = trunc(d_reg);
            end
            cmp_next = (ec_sel == rau_pkg::ERR_OK) && is_cmp && cmpw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= P_FIN;
            op_reg    <= rau_pkg::OP_NONE;
            an_reg <= '0; ad_reg <= '0; bn_reg <= '0; bd_reg <= '0;
            k_reg  <= '0;
            ga_reg <= '0; gb_reg <= '0;
            n_reg  <= '0; d_reg  <= '0;
            l_reg  <= '0; g_reg  <= '0;
            x_reg  <= '0; y_reg  <= '0;
            err_reg   <= 1'b0;
            half_reg  <= 1'b0;
            cmpw_reg  <= 1'b0;
            div_a_reg <= '0;
            div_b_reg <= '0;
            div_start_reg <= 1'b0;
            out_v_reg <= 1'b0;
            rn_reg    <= '0;
            rd_reg    <= '0;
            cmp_reg   <= 1'b0;
            ec_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            op_reg    <= op_next;
            an_reg <= an_next; ad_reg <= ad_next; bn_reg <= bn_next; bd_reg <= bd_next;
            k_reg  <= k_next;
            ga_reg <= ga_next; gb_reg <= gb_next;
            n_reg  <= n_next;  d_reg  <= d_next;
            l_reg  <= l_next;  g_reg  <= g_next;
            x_reg  <= x_next;  y_reg  <= y_next;
            err_reg   <= err_next;
            half_reg  <= half_next;
            cmpw_reg  <= cmpw_next;
            div_a_reg <= div_a_next;
            div_b_reg <= div_b_next;
            div_start_reg <= div_go;
            out_v_reg <= out_v_next;
            rn_reg    <= rn_next;
            rd_reg    <= rd_next;
            cmp_reg   <= cmp_next;
            ec_reg    <= ec_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_v_reg;
    assign res_num      = rn_reg;
    assign res_den      = rd_reg;
    assign compare_true = cmp_reg;
    assign error_code   = ec_reg;

endmodule

@@ rtl/rau_divider.sv @@
// Shared iterative signed divider, one quotient bit per cycle, truncating.
module rau_divider #(
    parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rau_pkg::div_ctl_t       ctl,
    input  logic [WIDTH-1:0]        dividend,
    input  logic [WIDTH-1:0]        divisor,
    output rau_pkg::div_sts_t       sts,
    output logic [WIDTH-1:0]        quotient,
    output logic [WIDTH-1:0]        remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[WIDTH-1]};
        trial     = shifted - {1'b0, d_reg};
        if (ctl.start)
        begin
            q_next    = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            qneg_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            rneg_next = dividend[WIDTH-1];
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                r_next = trial[WIDTH-1:0];
                q_next = {q_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[WIDTH-1:0];
                q_next = {q_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign quotient  = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = rneg_reg ? (~r_reg + 1'b1) : r_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;

endmodule

@@ test/tb.sv @@
// Testbench for the rational arithmetic unit: directed table plus random items.
module tb;

    localparam int W = 32;
    localparam int RANDOM_ITEMS = 530;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        logic [31:0] k;
    } frac_item_t;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        cmp;
        logic [1:0]  code;
    } frac_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] opcode = '0;
    logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0, scale_factor = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [W-1:0] res_num, res_den;
    logic compare_true;
    logic [1:0] error_code;

    frac_result_t expected_results[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  stimulus_done = 1'b0;
    bit  hold_off = 1'b0;

    rational_arithmetic_unit uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Wrapping signed helpers at 32 bits, truncating quotient and remainder.
    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b, ref bit err);
        logic [31:0] q;
        if (b == 0)
        begin
            err = 1'b1;
            return 0;
        end
        q = mag32(a) / mag32(b);
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        forever
        begin
            if (b == 0) return a;
            if (a == 0) return b;
            t = mag32(a) % mag32(b);
            if (a[31]) t = -t;
            a = b;
            b = t;
        end
    endfunction

    function automatic logic [31:0] lcm32(logic [31:0] a, logic [31:0] b, ref bit err);
        return quot32(a * b, gcd32(a, b), err);
    endfunction

    function automatic void lowest_terms(logic [31:0] n, logic [31:0] d,
                                         output logic [31:0] on, output logic [31:0] od,
                                         ref bit err);
        logic [31:0] g;
        on = 0;
        od = 0;
        if (d == 0)
        begin
            err = 1'b1;
            return;
        end
        g = gcd32(n, d);
        n = quot32(n, g, err);
        d = quot32(d, g, err);
        if (d[31])
        begin
            n = -n;
            d = -d;
        end
        on = n;
        od = d;
    endfunction

    function automatic bit fraction_lt(logic [31:0] fn, logic [31:0] fd,
                                       logic [31:0] gn, logic [31:0] gd, ref bit err);
        logic [31:0] l, x, y;
        l = lcm32(fd, gd, err);
        x = quot32(fn * l, fd, err);
        y = quot32(gn * l, gd, err);
        return $signed(x) < $signed(y);
    endfunction

    function automatic frac_result_t compute_fraction(frac_item_t it);
        frac_result_t r;
        logic [31:0] l, ka, kb;
        bit err;
        logic [1:0] code;
        err = 1'b0;
        code = rau_pkg::ERR_OK;
        r = '0;
        case (rau_pkg::opcode_t'(it.op))
            rau_pkg::OP_ADD:
            begin
                l = lcm32(it.ad, it.bd, err);
                ka = quot32(l, it.ad, err);
                kb = quot32(l, it.bd, err);
                lowest_terms(it.an * ka + it.bn * kb, l, r.num, r.den, err);
            end
            rau_pkg::OP_MUL:
                lowest_terms(it.an * it.bn, it.ad * it.bd, r.num, r.den, err);
            rau_pkg::OP_DIV:
                lowest_terms(it.an * it.bd, it.ad * it.bn, r.num, r.den, err);
            rau_pkg::OP_LESS:   r.cmp = fraction_lt(it.an, it.ad, it.bn, it.bd, err);
            rau_pkg::OP_GREAT:  r.cmp = fraction_lt(it.bn, it.bd, it.an, it.ad, err);
            rau_pkg::OP_REDUCE: lowest_terms(it.an, it.ad, r.num, r.den, err);
            rau_pkg::OP_SCALE:
            begin
                if (it.k == 0)
                    code = rau_pkg::ERR_SCALE;
                else
                begin
                    r.num = it.an * it.k;
                    r.den = it.ad * it.k;
                end
            end
            default: ;
        endcase
        if (err) code = rau_pkg::ERR_DIV0;
        if (code != rau_pkg::ERR_OK) r = '0;
        r.code = code;
        return r;
    endfunction

    // Random values lean toward small magnitudes so reductions are non-trivial.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h8000_0000 + $urandom_range(0, 2);
            2:       return 32'h7fff_ffff - $urandom_range(0, 2);
            3:       return 0;
            4, 5:    return $urandom_range(0, 60000) - 30000;
            default: return $urandom_range(0, 40) - 20;
        endcase
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    // Directed rows; a flag marks rows whose expectation is typed in by hand.
    typedef struct {
        frac_item_t   it;
        bit           typed;
        frac_result_t want;
    } directed_row_t;

    directed_row_t directed[] = '{
        '{'{rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 32'd0}, 1,
          '{32'd5, 32'd6, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4, 32'd0}, 1,
          '{32'd1, 32'd2, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_DIV0}},
        '{'{rau_pkg::OP_LESS, 32'd1, 32'd3, 32'd1, 32'd2, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b1, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_GREAT, 32'd1, 32'd3, 32'd1, 32'd2, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_REDUCE, -32'sd4, -32'sd6, 32'd0, 32'd0, 32'd0}, 1,
          '{32'd2, 32'd3, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_SCALE, 32'd3, 32'd5, 32'd0, 32'd0, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_SCALE}},
        '{'{rau_pkg::OP_SCALE, 32'd3, 32'd5, 32'd0, 32'd0, -32'sd1}, 1,
          '{-32'sd3, -32'sd5, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff}, 1, '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_OK}},
        '{'{rau_pkg::OP_REDUCE, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_DIV0}},
        '{'{rau_pkg::OP_LESS, 32'd1, 32'd0, 32'd1, 32'd2, 32'd0}, 1,
          '{32'd0, 32'd0, 1'b0, rau_pkg::ERR_DIV0}},
        // Most negative value divided by minus one, and its negation.
        '{'{rau_pkg::OP_REDUCE, 32'h8000_0000, -32'sd1, 32'd0, 32'd0, 32'd0}, 0,
          '{default: '0}},
        '{'{rau_pkg::OP_SCALE, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, -32'sd1}, 0,
          '{default: '0}},
        // A zero multiplier inside add, and an LCM that wraps to zero.
        '{'{rau_pkg::OP_ADD, 32'd0, 32'd7, 32'd3, 32'd5, 32'd0}, 0, '{default: '0}},
        '{'{rau_pkg::OP_ADD, 32'd1, 32'h0001_0000, 32'd1, 32'h0003_0000, 32'd0}, 0,
          '{default: '0}},
        '{'{rau_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000}, 0, '{default: '0}},
        '{'{rau_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, -32'sd3, 32'd9, 32'h7fff_ffff}, 0,
          '{default: '0}},
        '{'{rau_pkg::OP_GREAT, 32'h7fff_ffff, -32'sd1, 32'h8000_0000, 32'd3, 32'd0}, 0,
          '{default: '0}},
        '{'{rau_pkg::OP_LESS, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '{default: '0}},
        '{'{rau_pkg::OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
            32'h5555_5555}, 0, '{default: '0}}
    };

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(frac_item_t it, bit typed, frac_result_t want);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode <= it.op;
        a_num <= it.an;
        a_den <= it.ad;
        b_num <= it.bn;
        b_den <= it.bd;
        scale_factor <= it.k;
        in_valid <= 1'b1;
        expected_results.push_back(typed ? want : compute_fraction(it));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Sender: directed table, then random items with a long receiver hold-off.
    initial
    begin
        frac_item_t it;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100) hold_off = 1'b1;
            it.op = $urandom_range(0, 7);
            it.an = pick_value();
            it.ad = pick_value();
            it.bn = pick_value();
            it.bd = pick_value();
            it.k = pick_value();
            send_item(it, 1'b0, '0);
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver stall: random gaps, plus one long hold-off while items are offered.
    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            len = gap_length();
            out_stall <= (len != 0);
            if (len != 0) repeat (len - 1) @(negedge clk);
            if (len != 0)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Checker, watchdog and end of run.
    always @(posedge clk)
    begin
        frac_result_t want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h/%h", $time, res_num, res_den);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_num !== want.num)
                begin
                    $display("%0t: res_num expected %h actual %h", $time, want.num, res_num);
                    failures++;
                end
                if (res_den !== want.den)
                begin
                    $display("%0t: res_den expected %h actual %h", $time, want.den, res_den);
                    failures++;
                end
                if (compare_true !== want.cmp)
                begin
                    $display("%0t: compare_true expected %b actual %b", $time, want.cmp,
                             compare_true);
                    failures++;
                end
                if (error_code !== want.code)
                begin
                    $display("%0t: error_code expected %0d actual %0d", $time, want.code,
                             error_code);
                    failures++;
                end
            end
        end
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
